[rtl/occupancy_grid_ray_update_top_macros.svh]
// Assertion macros for the occupancy grid ray update block.
// Used by the port checker; expects clk and rst_n in the enclosing scope.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_TOP_MACROS_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_TOP_MACROS_SVH

// same-cycle implication
`define OGRU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OGRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ogru_pkg.sv]
// Shared types, constants and microcode ROM for the occupancy grid ray update.
// No dependencies; imported by ogru_req_if, ogru_rsp_if, the top, ogru_useq and ogru_dp.
`default_nettype none

package ogru_pkg;

    localparam int GRID_DIM   = 256;
    localparam int COORD_W    = 8;
    localparam int CFG_W      = 9;
    localparam int CNT_W      = 9;
    localparam int ERR_W      = 10;
    localparam int GRID_CELLS = GRID_DIM * GRID_DIM;
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int DIM_CMP_W  = ($clog2(GRID_DIM + 1) > COORD_W) ?
                                $clog2(GRID_DIM + 1) : COORD_W + 1;

    typedef logic [1:0] cell_t;
    localparam cell_t CELL_UNKNOWN  = 2'd0;
    localparam cell_t CELL_FREE     = 2'd1;
    localparam cell_t CELL_OCCUPIED = 2'd2;

    typedef logic [1:0] action_t;
    localparam action_t ACT_TRACE = 2'd0;
    localparam action_t ACT_FREE  = 2'd1;
    localparam action_t ACT_READ  = 2'd2;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd200;

    typedef enum logic [3:0] {
        STEP_EMIT,
        STEP_FETCH,
        STEP_DISPATCH,
        STEP_WALK,
        STEP_END,
        STEP_SINGLE,
        STEP_FREE,
        STEP_READ_CHK,
        STEP_READ,
        STEP_CLEAR,
        STEP_CLEAR_DONE
    } step_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_REQ,
        C_NOT_TRACE,
        C_NOT_FREE,
        C_NOT_READ,
        C_NOT_END,
        C_CLR_BUSY,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_FETCH,
        OP_WALK,
        OP_END,
        OP_FREE,
        OP_READ,
        OP_CLEAR,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        step_t  target;
    } uword_t;

    typedef struct packed {
        logic    req_valid;
        action_t action;
        logic    at_end;
        logic    clr_busy;
        logic    out_busy;
    } dp_status_t;

    function automatic logic in_dim(input logic [COORD_W-1:0] coord);
        return {{(DIM_CMP_W-COORD_W){1'b0}}, coord} < DIM_CMP_W'(GRID_DIM);
    endfunction

    // taken condition jumps to target, otherwise falls through to the next step
    function automatic uword_t ucode_rom(input step_t step);
        uword_t uw;
        case (step)
            STEP_EMIT:       uw = '{OP_EMIT,  C_OUT_BUSY,  STEP_EMIT};
            STEP_FETCH:      uw = '{OP_FETCH, C_NO_REQ,    STEP_FETCH};
            STEP_DISPATCH:   uw = '{OP_NOP,   C_NOT_TRACE, STEP_SINGLE};
            STEP_WALK:       uw = '{OP_WALK,  C_NOT_END,   STEP_WALK};
            STEP_END:        uw = '{OP_END,   C_ALWAYS,    STEP_EMIT};
            STEP_SINGLE:     uw = '{OP_NOP,   C_NOT_FREE,  STEP_READ_CHK};
            STEP_FREE:       uw = '{OP_FREE,  C_ALWAYS,    STEP_EMIT};
            STEP_READ_CHK:   uw = '{OP_NOP,   C_NOT_READ,  STEP_EMIT};
            STEP_READ:       uw = '{OP_READ,  C_ALWAYS,    STEP_EMIT};
            STEP_CLEAR:      uw = '{OP_CLEAR, C_CLR_BUSY,  STEP_CLEAR};
            STEP_CLEAR_DONE: uw = '{OP_NOP,   C_ALWAYS,    STEP_FETCH};
            default:         uw = '{OP_NOP,   C_ALWAYS,    STEP_FETCH};
        endcase
        return uw;
    endfunction

endpackage

`default_nettype wire

[rtl/ogru_req_if.sv]
// Request channel: valid/ready with the ray or cell request payload.
// Depends on ogru_pkg.
`default_nettype none

interface ogru_req_if import ogru_pkg::*;;
    logic                valid;
    logic                ready;
    action_t             action;
    logic [COORD_W-1:0]  start_x;
    logic [COORD_W-1:0]  start_y;
    logic [COORD_W-1:0]  end_x;
    logic [COORD_W-1:0]  end_y;

    modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

[rtl/ogru_rsp_if.sv]
// Result channel: valid/ready with cell state, range flag and write count.
// Depends on ogru_pkg.
`default_nettype none

interface ogru_rsp_if import ogru_pkg::*;;
    logic              valid;
    logic              ready;
    cell_t             cell_state;
    logic              out_of_range;
    logic [CNT_W-1:0]  cells_written;

    modport source (output valid, cell_state, out_of_range, cells_written, input ready);
    modport sink   (input valid, cell_state, out_of_range, cells_written, output ready);
endinterface

`default_nettype wire

[rtl/occupancy_grid_ray_update_top.sv]
// Top level of the occupancy grid ray update: sequencer plus datapath.
// Depends on ogru_pkg, ogru_req_if, ogru_rsp_if, ogru_useq, ogru_dp.
//
//   port       dir  kind         contents
//   req        in   valid/ready  action, start_x, start_y, end_x, end_y
//   rsp        out  valid/ready  cell_state, out_of_range, cells_written
//   cfg_*      in   write only   index 0 grid_width, index 1 grid_height
//
// Trace: one walk step per ray cell but the end, on the single grid RAM port.
// After reset a clearing pass writes every cell unknown, with req.ready low;
// config writes are taken throughout. rsp has an output register: the next
// request is taken while a result waits, and only the emit step holds while
// that register is full and rsp.ready is low.
`default_nettype none

module occupancy_grid_ray_update_top import ogru_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    ogru_req_if.sink               req,
    ogru_rsp_if.source             rsp
);

    dp_op_t     op;
    dp_status_t status;

    ogru_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    ogru_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .status    (status),
        .req       (req),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

[rtl/ogru_ram.sv]
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
`default_nettype none

module ogru_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  addr,
    input  wire logic [WIDTH-1:0]          wdata,
    output      logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[rtl/ogru_useq.sv]
// Microcode sequencer: step counter, control ROM and jump conditions.
// Depends on ogru_pkg.
`default_nettype none

module ogru_useq import ogru_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_status_t status,
    output dp_op_t          op
);

    step_t  upc_reg;
    step_t  upc_next;
    uword_t uw;
    logic   take;

    assign uw = ucode_rom(upc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // next step
    always_comb
    begin
        case (uw.cond)
            C_ALWAYS:    take = 1'b1;
            C_NO_REQ:    take = !status.req_valid;
            C_NOT_TRACE: take = status.action != ACT_TRACE;
            C_NOT_FREE:  take = status.action != ACT_FREE;
            C_NOT_READ:  take = status.action != ACT_READ;
            C_NOT_END:   take = !status.at_end;
            C_CLR_BUSY:  take = status.clr_busy;
            C_OUT_BUSY:  take = status.out_busy;
            default:     take = 1'b1;
        endcase
        upc_next = take ? uw.target : step_t'(4'(upc_reg) + 4'd1);
    end

    // control word out
    always_comb
    begin
        op = uw.op;
    end

endmodule

`default_nettype wire

[rtl/ogru_dp.sv]
// Datapath: config registers, Bresenham walk registers, grid RAM, output register.
// Depends on ogru_pkg, ogru_ram, ogru_req_if, ogru_rsp_if.
`default_nettype none

module ogru_dp import ogru_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire dp_op_t            op,
    output dp_status_t             status,
    ogru_req_if.sink               req,
    ogru_rsp_if.source             rsp
);

    logic [CFG_W-1:0]         grid_width_reg;
    logic [CFG_W-1:0]         grid_height_reg;
    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic [ADDR_W-1:0]        clr_cnt_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;

    action_t                  act_reg,   act_next;
    logic [COORD_W-1:0]       x_reg,     x_next;
    logic [COORD_W-1:0]       y_reg,     y_next;
    logic [COORD_W-1:0]       x1_reg,    x1_next;
    logic [COORD_W-1:0]       y1_reg,    y1_next;
    logic [COORD_W-1:0]       dx_reg,    dx_next;
    logic [COORD_W-1:0]       dy_reg,    dy_next;
    logic                     sx_neg_reg, sx_neg_next;
    logic                     sy_neg_reg, sy_neg_next;
    logic signed [ERR_W-1:0]  err_reg,   err_next;
    logic [CNT_W-1:0]         cnt_reg,   cnt_next;
    logic                     oor_reg,   oor_next;
    cell_t                    state_reg, state_next;
    cell_t                    out_state_reg, out_state_next;
    logic                     out_oor_reg,   out_oor_next;
    logic [CNT_W-1:0]         out_cnt_reg,   out_cnt_next;

    logic                     req_fire;
    logic                     at_end;
    logic                     in_cur;
    logic                     out_busy;
    logic                     emit;
    logic [ADDR_W-1:0]        cur_addr;
    logic signed [ERR_W:0]    e2;
    logic signed [ERR_W:0]    dx_s;
    logic signed [ERR_W:0]    dy_s;
    logic                     move_x;
    logic                     move_y;
    logic signed [ERR_W:0]    err_sum;
    logic [COORD_W-1:0]       ld_dx;
    logic [COORD_W-1:0]       ld_dy;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_addr;
    cell_t                    ram_wdata;
    cell_t                    ram_rdata;

    assign req.ready = (op == OP_FETCH);
    assign req_fire  = req.valid && req.ready;
    assign at_end    = (x_reg == x1_reg) && (y_reg == y1_reg);
    assign in_cur    = ({1'b0, x_reg} < grid_width_reg) && ({1'b0, y_reg} < grid_height_reg)
                       && in_dim(x_reg) && in_dim(y_reg);
    assign out_busy  = out_valid_reg && !rsp.ready;
    assign emit      = (op == OP_EMIT) && !out_busy;
    assign cur_addr  = ADDR_W'(ADDR_W'(y_reg) * ADDR_W'(GRID_DIM)) + ADDR_W'(x_reg);

    assign status.req_valid = req.valid;
    assign status.action    = act_reg;
    assign status.at_end    = at_end;
    assign status.clr_busy  = clr_cnt_reg != ADDR_W'(GRID_CELLS - 1);
    assign status.out_busy  = out_busy;

    assign rsp.valid         = out_valid_reg;
    assign rsp.cell_state    = out_state_reg;
    assign rsp.out_of_range  = out_oor_reg;
    assign rsp.cells_written = out_cnt_reg;

    // Bresenham step terms
    assign e2      = {err_reg, 1'b0};
    assign dx_s    = $signed({3'b000, dx_reg});
    assign dy_s    = $signed({3'b000, dy_reg});
    assign move_x  = e2 > -dy_s;
    assign move_y  = e2 < dx_s;
    assign err_sum = $signed({err_reg[ERR_W-1], err_reg}) - (move_x ? dy_s : '0)
                     + (move_y ? dx_s : '0);

    assign ld_dx = (req.end_x > req.start_x) ? req.end_x - req.start_x
                                             : req.start_x - req.end_x;
    assign ld_dy = (req.end_y > req.start_y) ? req.end_y - req.start_y
                                             : req.start_y - req.end_y;

    always_comb
    begin
        act_next       = act_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        err_next       = err_reg;
        cnt_next       = cnt_reg;
        oor_next       = oor_reg;
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_state_next = out_state_reg;
        out_oor_next   = out_oor_reg;
        out_cnt_next   = out_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        ram_we         = 1'b0;
        ram_addr       = cur_addr;
        ram_wdata      = CELL_FREE;

        case (op)
            OP_FETCH:
            begin
                if (req_fire)
                begin
                    act_next    = req.action;
                    x_next      = req.start_x;
                    y_next      = req.start_y;
                    x1_next     = req.end_x;
                    y1_next     = req.end_y;
                    dx_next     = ld_dx;
                    dy_next     = ld_dy;
                    sx_neg_next = !(req.start_x < req.end_x);
                    sy_neg_next = !(req.start_y < req.end_y);
                    err_next    = $signed(ERR_W'(ld_dx)) - $signed(ERR_W'(ld_dy));
                    cnt_next    = '0;
                    oor_next    = 1'b0;
                    state_next  = CELL_UNKNOWN;
                end
            end
            OP_WALK:
            begin
                if (!at_end)
                begin
                    ram_we   = in_cur;
                    cnt_next = cnt_reg + CNT_W'(in_cur);
                    err_next = ERR_W'(err_sum);
                    if (move_x)
                    begin
                        x_next = sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                    end
                    if (move_y)
                    begin
                        y_next = sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
                    end
                end
            end
            OP_END:
            begin
                ram_we    = in_cur;
                ram_wdata = CELL_OCCUPIED;
                cnt_next  = cnt_reg + CNT_W'(in_cur);
                oor_next  = !in_cur;
            end
            OP_FREE:
            begin
                ram_we   = in_cur;
                cnt_next = cnt_reg + CNT_W'(in_cur);
                oor_next = !in_cur;
            end
            OP_READ:
            begin
                oor_next   = !in_cur;
                state_next = in_cur ? ram_rdata : CELL_UNKNOWN;
            end
            OP_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = CELL_UNKNOWN;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            OP_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_state_next = state_reg;
                    out_oor_next   = oor_reg;
                    out_cnt_next   = cnt_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_RESET;
            grid_height_reg <= CFG_RESET;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            act_reg         <= ACT_TRACE;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_GRID_WIDTH))
            begin
                grid_width_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_GRID_HEIGHT))
            begin
                grid_height_reg <= cfg_data;
            end
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            act_reg       <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        x1_reg        <= x1_next;
        y1_reg        <= y1_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        sx_neg_reg    <= sx_neg_next;
        sy_neg_reg    <= sy_neg_next;
        err_reg       <= err_next;
        cnt_reg       <= cnt_next;
        oor_reg       <= oor_next;
        state_reg     <= state_next;
        out_state_reg <= out_state_next;
        out_oor_reg   <= out_oor_next;
        out_cnt_reg   <= out_cnt_next;
    end

    ogru_ram #(
        .WIDTH ($bits(cell_t)),
        .DEPTH (GRID_CELLS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

[rtl/ogru_chk.sv]
// Port checker for the occupancy grid ray update top, attached by bind.
// Depends on occupancy_grid_ray_update_top_macros.svh.
`default_nettype none

`include "occupancy_grid_ray_update_top_macros.svh"

module ogru_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [1:0] rsp_cell_state,
    input wire logic       rsp_out_of_range,
    input wire logic [8:0] rsp_cells_written
);

    `OGRU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cell_state) && $stable(rsp_out_of_range) && $stable(rsp_cells_written), "stalled result changed")

    // a read result carries a known cell only when in range and nothing written
    `OGRU_ASSERT_SAME(a_read_clean, rsp_valid && (rsp_cell_state != 2'd0), !rsp_out_of_range && (rsp_cells_written == 9'd0), "read result mixed with write")

    `OGRU_ASSERT_SAME(a_state_code, rsp_valid, rsp_cell_state != 2'd3, "illegal cell state")

    `OGRU_ASSERT_SAME(a_count_max, rsp_valid, rsp_cells_written <= 9'd256, "write count too large")

endmodule

bind occupancy_grid_ray_update_top ogru_chk u_ogru_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_cell_state    (rsp.cell_state),
    .rsp_out_of_range  (rsp.out_of_range),
    .rsp_cells_written (rsp.cells_written)
);

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for occupancy_grid_ray_update_top: directed table, then random phases.
// Uses ogru_pkg, ogru_req_if, ogru_rsp_if. Each result is checked against a pin or grid model.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ogru_pkg::*;

    localparam action_t ACT_UNUSED      = 2'd3;
    localparam int      PHASES          = 8;
    localparam int      REQS_PER_PHASE  = 194;
    localparam int      HOLD_OFF_CYCLES = 400;
    localparam int      DRAIN_CYCLES    = 300;

    typedef struct packed {
        action_t            action;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } ray_req_t;

    typedef struct packed {
        cell_t              cell_state;
        logic               out_of_range;
        logic [CNT_W-1:0]   cells_written;
    } grid_result_t;

    typedef struct packed {
        logic               is_cfg;
        logic [CFG_W-1:0]   width;
        logic [CFG_W-1:0]   height;
        ray_req_t           req;
        logic               pinned;
        grid_result_t       res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ogru_req_if req_ch();
    ogru_rsp_if rsp_ch();

    occupancy_grid_ray_update_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    cell_t            grid_map [GRID_CELLS];
    logic [CFG_W-1:0] map_width  = CFG_RESET;
    logic [CFG_W-1:0] map_height = CFG_RESET;
    grid_result_t     pending_results [$];
    stim_row_t        directed_rows [$];

    logic             pin_expected = 1'b0;
    grid_result_t     pin_result   = '0;
    bit               idle_on      = 1'b1;
    bit               hold_off_req = 1'b0;
    logic [COORD_W-1:0] last_sx, last_sy, last_ex, last_ey;

    int n_trace, n_free, n_read, n_unused, n_checked, n_errors, n_settings, n_holds;
    int max_written;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit cell_inside(int x, int y);
        int w;
        int h;
        w = (map_width > GRID_DIM) ? GRID_DIM : int'(map_width);
        h = (map_height > GRID_DIM) ? GRID_DIM : int'(map_height);
        return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    function automatic int mark_cell(int x, int y, cell_t v);
        if (!cell_inside(x, y))
            return 0;
        grid_map[y * GRID_DIM + x] = v;
        return 1;
    endfunction

    function automatic int trace_into_map(int x0, int y0, int x1, int y1);
        int dx, dy, sx, sy, err, e2, x, y, count;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        sx = (x0 < x1) ? 1 : -1;
        sy = (y0 < y1) ? 1 : -1;
        err = dx - dy;
        x = x0;
        y = y0;
        count = 0;
        while (x != x1 || y != y1)
        begin
            count += mark_cell(x, y, CELL_FREE);
            e2 = 2 * err;
            if (e2 > -dy)
            begin
                err -= dy;
                x += sx;
            end
            if (e2 < dx)
            begin
                err += dx;
                y += sy;
            end
        end
        count += mark_cell(x1, y1, CELL_OCCUPIED);
        return count;
    endfunction

    // applies one request to the local grid and returns the result it should give
    function automatic grid_result_t predict_update(ray_req_t r);
        grid_result_t res;
        res = '0;
        case (r.action)
            ACT_TRACE:
            begin
                res.out_of_range  = !cell_inside(r.end_x, r.end_y);
                res.cells_written = CNT_W'(trace_into_map(r.start_x, r.start_y,
                                                          r.end_x, r.end_y));
            end
            ACT_FREE:
            begin
                res.out_of_range  = !cell_inside(r.start_x, r.start_y);
                res.cells_written = CNT_W'(mark_cell(r.start_x, r.start_y, CELL_FREE));
            end
            ACT_READ:
            begin
                if (cell_inside(r.start_x, r.start_y))
                    res.cell_state = grid_map[r.start_y * GRID_DIM + r.start_x];
                else
                    res.out_of_range = 1'b1;
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    function automatic stim_row_t req_row(action_t a, int sx, int sy, int ex, int ey);
        stim_row_t row;
        row = '0;
        row.req = '{a, COORD_W'(sx), COORD_W'(sy), COORD_W'(ex), COORD_W'(ey)};
        return row;
    endfunction

    function automatic stim_row_t pin_row(action_t a, int sx, int sy, int ex, int ey,
                                          cell_t st, bit oor, int cnt);
        stim_row_t row;
        row = req_row(a, sx, sy, ex, ey);
        row.pinned = 1'b1;
        row.res = '{st, oor, CNT_W'(cnt)};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(int w, int h);
        stim_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.width  = CFG_W'(w);
        row.height = CFG_W'(h);
        return row;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_W-1:0] near_coord(int c, int span);
        int v;
        v = c + $urandom_range(0, 2 * span) - span;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return COORD_W'(v);
    endfunction

    // edges of the configured grid are favoured
    function automatic logic [COORD_W-1:0] pick_coord(logic [CFG_W-1:0] bound);
        int b;
        b = (bound > GRID_DIM) ? GRID_DIM : int'(bound);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return COORD_W'((b > 0) ? b - 1 : 0);
            3: return COORD_W'((b < GRID_DIM) ? b : GRID_DIM - 1);
            4, 5, 6: return COORD_W'($urandom_range(0, (b > 0) ? b - 1 : 0));
            default: return COORD_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic ray_req_t random_request();
        ray_req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.action  = (pick < 45) ? ACT_TRACE : (pick < 60) ? ACT_FREE :
                    (pick < 95) ? ACT_READ : ACT_UNUSED;
        r.start_x = pick_coord(map_width);
        r.start_y = pick_coord(map_height);
        r.end_x   = COORD_W'($urandom_range(0, 255));
        r.end_y   = COORD_W'($urandom_range(0, 255));
        if (r.action == ACT_TRACE)
        begin
            // mostly short rays, now and then one across the grid
            if ($urandom_range(0, 9) != 0)
            begin
                pick = $urandom_range(1, 32);
                r.end_x = near_coord(r.start_x, pick);
                r.end_y = near_coord(r.start_y, pick);
            end
            last_sx = r.start_x;
            last_sy = r.start_y;
            last_ex = r.end_x;
            last_ey = r.end_y;
        end
        else if (r.action == ACT_READ && $urandom_range(0, 1))
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    r.start_x = last_ex;
                    r.start_y = last_ey;
                end
                1:
                begin
                    r.start_x = COORD_W'((int'(last_sx) + int'(last_ex)) / 2);
                    r.start_y = COORD_W'((int'(last_sy) + int'(last_ey)) / 2);
                end
                default:
                begin
                    r.start_x = near_coord(last_ex, 2);
                    r.start_y = near_coord(last_ey, 2);
                end
            endcase
        end
        return r;
    endfunction

    // entered just after a falling edge
    task automatic send_request(input ray_req_t r, input logic pinned, input grid_result_t res);
        int gap;
        req_ch.valid   = 1'b1;
        req_ch.action  = r.action;
        req_ch.start_x = r.start_x;
        req_ch.start_y = r.start_y;
        req_ch.end_x   = r.end_x;
        req_ch.end_y   = r.end_y;
        pin_expected   = pinned;
        pin_result     = res;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic write_grid_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = CFG_GRID_WIDTH;
        cfg_data  = w;
        @(negedge clk);
        cfg_index = CFG_GRID_HEIGHT;
        cfg_data  = h;
        @(negedge clk);
        cfg_we    = 1'b0;
        n_settings++;
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        n_errors++;
    endtask

    always @(posedge clk)
    begin
        grid_result_t got;
        grid_result_t want;
        ray_req_t     r;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_GRID_WIDTH)
                    map_width = cfg_data;
                else
                    map_height = cfg_data;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.cell_state, rsp_ch.out_of_range, rsp_ch.cells_written};
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    n_errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.cell_state !== want.cell_state)
                        report_mismatch("cell_state", int'(want.cell_state),
                                        int'(got.cell_state));
                    if (got.out_of_range !== want.out_of_range)
                        report_mismatch("out_of_range", int'(want.out_of_range),
                                        int'(got.out_of_range));
                    if (got.cells_written !== want.cells_written)
                        report_mismatch("cells_written", int'(want.cells_written),
                                        int'(got.cells_written));
                    if (int'(want.cells_written) > max_written)
                        max_written = int'(want.cells_written);
                    n_checked++;
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                r = '{req_ch.action, req_ch.start_x, req_ch.start_y,
                      req_ch.end_x, req_ch.end_y};
                want = predict_update(r);
                if (pin_expected)
                    want = pin_result;
                pending_results.push_back(want);
                case (r.action)
                    ACT_TRACE: n_trace++;
                    ACT_FREE:  n_free++;
                    ACT_READ:  n_read++;
                    default:   n_unused++;
                endcase
            end
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    initial
    begin
        int n;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                n_holds++;
            end
            if (idle_on && $urandom_range(0, 99) < 30)
            begin
                rsp_ch.ready = 1'b0;
                n = pick_gap();
                repeat (n) @(negedge clk);
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    initial
    begin
        #30_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        int phase;
        int k;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_GRID_WIDTH;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.action  = ACT_TRACE;
        req_ch.start_x = '0;
        req_ch.start_y = '0;
        req_ch.end_x   = '0;
        req_ch.end_y   = '0;
        last_sx = '0;
        last_sy = '0;
        last_ex = '0;
        last_ey = '0;
        foreach (grid_map[i])
            grid_map[i] = CELL_UNKNOWN;

        // grid 200 x 200 after reset, every cell unknown
        directed_rows.push_back(pin_row(ACT_READ, 0, 0, 0, 0, CELL_UNKNOWN, 0, 0));
        directed_rows.push_back(pin_row(ACT_READ, 199, 199, 0, 0, CELL_UNKNOWN, 0, 0));
        directed_rows.push_back(pin_row(ACT_READ, 200, 0, 0, 0, CELL_UNKNOWN, 1, 0));
        directed_rows.push_back(pin_row(ACT_READ, 255, 255, 0, 0, CELL_UNKNOWN, 1, 0));
        directed_rows.push_back(pin_row(ACT_FREE, 0, 0, 0, 0, CELL_UNKNOWN, 0, 1));
        directed_rows.push_back(pin_row(ACT_READ, 0, 0, 0, 0, CELL_FREE, 0, 0));
        directed_rows.push_back(pin_row(ACT_FREE, 200, 5, 0, 0, CELL_UNKNOWN, 1, 0));
        directed_rows.push_back(pin_row(ACT_FREE, 0, 255, 0, 0, CELL_UNKNOWN, 1, 0));
        directed_rows.push_back(pin_row(ACT_TRACE, 10, 10, 10, 10, CELL_UNKNOWN, 0, 1));
        directed_rows.push_back(pin_row(ACT_READ, 10, 10, 0, 0, CELL_OCCUPIED, 0, 0));
        directed_rows.push_back(pin_row(ACT_TRACE, 0, 0, 199, 0, CELL_UNKNOWN, 0, 200));
        directed_rows.push_back(pin_row(ACT_TRACE, 0, 0, 255, 255, CELL_UNKNOWN, 1, 200));
        directed_rows.push_back(req_row(ACT_TRACE, 255, 0, 0, 0));
        directed_rows.push_back(req_row(ACT_TRACE, 0, 199, 199, 0));
        directed_rows.push_back(req_row(ACT_TRACE, 5, 7, 60, 23));
        directed_rows.push_back(req_row(ACT_TRACE, 30, 100, 33, 0));
        directed_rows.push_back(req_row(ACT_READ, 100, 0, 0, 0));
        directed_rows.push_back(req_row(ACT_READ, 57, 22, 0, 0));
        directed_rows.push_back(pin_row(ACT_UNUSED, 255, 255, 255, 255, CELL_UNKNOWN, 0, 0));
        directed_rows.push_back(pin_row(ACT_UNUSED, 0, 0, 0, 0, CELL_UNKNOWN, 0, 0));
        // zero size: nothing is inside
        directed_rows.push_back(cfg_row(0, 0));
        directed_rows.push_back(pin_row(ACT_TRACE, 0, 0, 5, 5, CELL_UNKNOWN, 1, 0));
        directed_rows.push_back(pin_row(ACT_READ, 0, 0, 0, 0, CELL_UNKNOWN, 1, 0));
        // registers past the grid dimension clamp to it
        directed_rows.push_back(cfg_row(511, 300));
        directed_rows.push_back(pin_row(ACT_READ, 255, 255, 0, 0, CELL_UNKNOWN, 0, 0));
        directed_rows.push_back(pin_row(ACT_TRACE, 250, 250, 255, 255, CELL_UNKNOWN, 0, 6));
        directed_rows.push_back(pin_row(ACT_READ, 255, 255, 0, 0, CELL_OCCUPIED, 0, 0));
        directed_rows.push_back(cfg_row(1, 1));
        directed_rows.push_back(pin_row(ACT_FREE, 0, 0, 0, 0, CELL_UNKNOWN, 0, 1));
        directed_rows.push_back(pin_row(ACT_TRACE, 0, 0, 0, 1, CELL_UNKNOWN, 1, 1));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_grid_size(directed_rows[i].width, directed_rows[i].height);
            else
                send_request(directed_rows[i].req, directed_rows[i].pinned,
                             directed_rows[i].res);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin w = CFG_W'(256); h = CFG_W'(256); end
                1: begin w = CFG_W'($urandom_range(1, 256)); h = CFG_W'($urandom_range(1, 256)); end
                2: begin w = CFG_W'(1); h = CFG_W'(1); end
                3: begin w = CFG_W'(511); h = CFG_W'(511); end
                4: begin w = '0; h = CFG_W'($urandom_range(0, 511)); end
                5: begin w = CFG_W'($urandom_range(0, 511)); h = CFG_W'($urandom_range(0, 511)); end
                6: begin w = CFG_W'(256); h = CFG_W'(1); end
                default: begin w = CFG_RESET; h = CFG_RESET; end
            endcase
            write_grid_size(w, h);
            idle_on = (phase != 2 && phase != 6);
            for (k = 0; k < REQS_PER_PHASE; k++)
            begin
                if (phase == 1 && k == 40)
                    hold_off_req = 1'b1;
                send_request(random_request(), 1'b0, '0);
            end
        end
        req_ch.valid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d traces, %0d set-free, %0d reads, %0d unused-code requests",
                 n_trace, n_free, n_read, n_unused);
        $display("over %0d grid sizes; %0d results checked, largest write count %0d, %0d hold-offs",
                 n_settings, n_checked, max_written, n_holds);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/ogru_pkg.sv
rtl/ogru_req_if.sv
rtl/ogru_rsp_if.sv
rtl/ogru_ram.sv
rtl/ogru_useq.sv
rtl/ogru_dp.sv
rtl/occupancy_grid_ray_update_top.sv
rtl/ogru_chk.sv
sim/tb.sv
